FILE: rtl/tscs_pkg.sv
// ----------------------------------------------------------------------------
// tscs_pkg: shared types and constants of the trie string count store
// sizes of the node pool and alphabet, the node entry layout and field codes
// ----------------------------------------------------------------------------
package tscs_pkg;

    // pool and alphabet sizing
    localparam int NODE_COUNT     = 4096;
    localparam int ALPHABET_SIZE  = 26;
    localparam int COUNT_BITS     = 16;

    localparam int NODE_BITS      = $clog2(NODE_COUNT);
    localparam int LETTER_BITS    = 5;
    localparam int LETTER_CMP_BITS = 7;
    localparam int SLOT_COUNT     = NODE_COUNT * ALPHABET_SIZE;
    localparam int SLOT_BITS      = $clog2(SLOT_COUNT);
    localparam int OUT_COUNT_BITS = 16;

    typedef logic [NODE_BITS-1:0]      node_id_t;
    typedef logic [SLOT_BITS-1:0]      slot_t;
    typedef logic [LETTER_BITS-1:0]    letter_t;
    typedef logic [COUNT_BITS-1:0]     count_t;
    typedef logic [OUT_COUNT_BITS-1:0] out_count_t;

    // per-node record: the link that created the node, and its word count
    typedef struct packed {
        node_id_t parent;
        letter_t  letter;
        count_t   cnt;
    } node_entry_t;

    // field codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam node_id_t   ROOT_NODE     = '0;
    localparam node_id_t   LAST_NODE     = node_id_t'(NODE_COUNT - 1);
    localparam count_t     COUNT_MAX     = '1;
    localparam out_count_t OUT_COUNT_MAX = '1;

endpackage

FILE: rtl/trie_string_count_store.sv
// ----------------------------------------------------------------------------
// trie_string_count_store: array trie with per-word occurrence counts
// walks one letter per item through a child link memory, allocates nodes
// from a bump counter on insert and reports the count on the last letter
// ----------------------------------------------------------------------------
// sequence: a walked letter keeps busy high through the link read, node read and
//   check states, a last letter also through a finishing state, and its result strobes in the next cycle;
//   a bad letter, or any letter after a missed link, skips the reads and the check.
// a new item is taken only while idle, so each walked letter finishes its two dependent reads first.
// results strobe for one cycle, the receiver cannot stall. reset clears control
//   and the node counter only; links are checked against each node's parent.
module trie_string_count_store (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     mode,
    input  logic [4:0]               letter,
    input  logic                     last,
    output logic                     valid,
    output logic [15:0]              count,
    output logic                     status
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDC  = 3'd1;
    localparam logic [2:0] S_RDN  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // control state
    logic [2:0]          state_reg, state_next;
    tscs_pkg::node_id_t  cursor_reg, cursor_next;
    tscs_pkg::node_id_t  nf_reg, nf_next;
    logic                missing_reg, missing_next;
    logic                overflow_reg, overflow_next;
    logic                valid_reg, valid_next;

    // item and datapath registers
    logic                   mode_reg;
    tscs_pkg::letter_t      letter_reg;
    logic                   last_reg;
    tscs_pkg::slot_t        slot_reg;
    tscs_pkg::node_id_t     child_q;
    tscs_pkg::node_entry_t  node_q;
    tscs_pkg::node_entry_t  entry_reg, entry_next;
    tscs_pkg::out_count_t   count_reg, count_next;
    logic                   status_reg, status_next;

    // memories
    tscs_pkg::node_id_t     child_mem [0:tscs_pkg::SLOT_COUNT-1];
    tscs_pkg::node_entry_t  node_mem  [0:tscs_pkg::NODE_COUNT-1];

    logic                   accept;
    logic                   in_range;
    logic                   link_ok;
    logic                   pool_full;
    tscs_pkg::node_id_t     new_node;
    logic                   child_we;
    logic                   node_we;
    tscs_pkg::node_id_t     node_wr_addr;
    tscs_pkg::node_entry_t  node_wr_data;
    logic                   hit;
    tscs_pkg::count_t       report;
    logic [31:0]            report_wide;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign valid  = valid_reg;
    assign count  = count_reg;
    assign status = status_reg;

    // link check: a read link is real only if it names an allocated node
    // whose recorded parent and letter match the current node and letter
    assign in_range  = tscs_pkg::LETTER_CMP_BITS'(letter)
                       < tscs_pkg::LETTER_CMP_BITS'(tscs_pkg::ALPHABET_SIZE);
    assign link_ok   = (child_q != tscs_pkg::ROOT_NODE) && (child_q <= nf_reg)
                       && (node_q.parent == cursor_reg) && (node_q.letter == letter_reg);
    assign pool_full = (nf_reg >= tscs_pkg::LAST_NODE);
    assign new_node  = nf_reg + 1'b1;
    assign hit       = !missing_reg && !overflow_reg;

    // sequencer and next-state logic
    always_comb
    begin
        state_next    = state_reg;
        cursor_next   = cursor_reg;
        nf_next       = nf_reg;
        missing_next  = missing_reg;
        overflow_next = overflow_reg;
        valid_next    = 1'b0;
        entry_next    = entry_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        child_we      = 1'b0;
        node_we       = 1'b0;
        node_wr_addr  = cursor_reg;
        node_wr_data  = entry_reg;
        report        = '0;
        report_wide   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!missing_reg && !overflow_reg && in_range)
                    begin
                        state_next = S_RDC;
                    end
                    else
                    begin
                        if (!missing_reg && !overflow_reg)
                        begin
                            missing_next = 1'b1;
                        end
                        if (last)
                        begin
                            state_next = S_FIN;
                        end
                    end
                end
            end
            S_RDC:
            begin
                state_next = S_RDN;
            end
            S_RDN:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (link_ok)
                begin
                    cursor_next = child_q;
                    entry_next  = node_q;
                end
                else if (mode_reg == tscs_pkg::MODE_QUERY)
                begin
                    missing_next = 1'b1;
                end
                else if (pool_full)
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    // allocate a fresh node and record where it hangs
                    nf_next             = new_node;
                    cursor_next         = new_node;
                    child_we            = 1'b1;
                    node_we             = 1'b1;
                    node_wr_addr        = new_node;
                    node_wr_data.parent = cursor_reg;
                    node_wr_data.letter = letter_reg;
                    node_wr_data.cnt    = '0;
                    entry_next          = node_wr_data;
                end
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                // bump a hit's count on insert unless saturated, report it (zero on a miss), then return to the root
                if (hit && (mode_reg == tscs_pkg::MODE_INSERT)
                    && (entry_reg.cnt != tscs_pkg::COUNT_MAX))
                begin
                    node_we          = 1'b1;
                    node_wr_addr     = cursor_reg;
                    node_wr_data.cnt = entry_reg.cnt + 1'b1;
                end
                report      = hit ? node_wr_data.cnt : '0;
                report_wide = 32'(report);
                count_next  = (report_wide > 32'(tscs_pkg::OUT_COUNT_MAX))
                              ? tscs_pkg::OUT_COUNT_MAX
                              : report_wide[tscs_pkg::OUT_COUNT_BITS-1:0];
                status_next   = overflow_reg ? tscs_pkg::STATUS_FULL : tscs_pkg::STATUS_OK;
                valid_next    = 1'b1;
                cursor_next   = tscs_pkg::ROOT_NODE;
                missing_next  = 1'b0;
                overflow_next = 1'b0;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cursor_reg   <= tscs_pkg::ROOT_NODE;
            nf_reg       <= tscs_pkg::ROOT_NODE;
            missing_reg  <= 1'b0;
            overflow_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            nf_reg       <= nf_next;
            missing_reg  <= missing_next;
            overflow_reg <= overflow_next;
            valid_reg    <= valid_next;
        end
    end

    // item capture and slot address
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode;
            letter_reg <= letter;
            last_reg   <= last;
            slot_reg   <= tscs_pkg::SLOT_BITS'(cursor_reg)
                          * tscs_pkg::SLOT_BITS'(tscs_pkg::ALPHABET_SIZE)
                          + tscs_pkg::SLOT_BITS'(letter);
        end
        entry_reg  <= entry_next;
        count_reg  <= count_next;
        status_reg <= status_next;
    end

    // child link memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RDC)
        begin
            child_q <= child_mem[slot_reg];
        end
        if (child_we)
        begin
            child_mem[slot_reg] <= new_node;
        end
    end

    // node record memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RDN)
        begin
            node_q <= node_mem[child_q];
        end
        if (node_we)
        begin
            node_mem[node_wr_addr] <= node_wr_data;
        end
    end

    // checks
    a_valid_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> $past(state_reg == S_FIN))
        else $error("result strobe without a finishing step");

    a_full_reports_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (status_reg == tscs_pkg::STATUS_FULL)) |-> (count_reg == '0))
        else $error("dropped insert reported a nonzero count");

    a_cursor_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= nf_reg)
        else $error("cursor points past the allocated nodes");

    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        (nf_reg != $past(nf_reg)) |-> (nf_reg == $past(nf_reg) + 1'b1))
        else $error("node counter moved by other than one");

endmodule
